// ----- design/wpcm_pkg.sv -----
// Shared constants, types and helpers for the sliding-window peak counter.
// No dependencies.
package wpcm_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int MAX_LEN     = 65536;
  localparam int SAMPLE_BITS = 32;

  localparam int WIN_W  = 11;
  localparam int IDX_W  = 17;
  localparam int CNT_W  = 10;
  localparam int LEFT_W = 16;
  localparam int OUT_W  = 11;

  localparam int CELLS = MAX_WINDOW - 2;
  localparam int DLY_W = $clog2(CELLS);

  typedef struct packed {
    logic shift;
    logic load_en;
    logic bit_in;
  } cell_ctrl_t;

  typedef struct packed {
    logic [OUT_W-1:0] count;
    logic [IDX_W-1:0] left;
    logic             err;
  } result_t;

  function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] k);
    logic [WIN_W-1:0] r;
    r = k;
    if (k < WIN_W'(3)) r = WIN_W'(3);
    else if (k > WIN_W'(MAX_WINDOW)) r = WIN_W'(MAX_WINDOW);
    return r;
  endfunction

endpackage

// ----- design/wpcm_cell.sv -----
// One stage of the peak-flag delay line: holds one flag, shifts toward cell 0.
// Depends on wpcm_pkg.
module wpcm_cell (
  input  logic                  clk,
  input  wpcm_pkg::cell_ctrl_t  ctrl,
  input  logic                  sel,
  input  logic                  from_next,
  output logic                  q
);
  import wpcm_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      q <= (sel && ctrl.load_en) ? ctrl.bit_in : from_next;
    end
  end

endmodule

// ----- design/wpcm_chain.sv -----
// Row of delay cells; a new flag enters at load_pos and leaves at cell 0
// load_pos+1 shifts later. Depends on wpcm_pkg and wpcm_cell.
module wpcm_chain (
  input  logic                   clk,
  input  wpcm_pkg::cell_ctrl_t   ctrl,
  input  logic [wpcm_pkg::DLY_W-1:0] load_pos,
  output logic                   old_bit
);
  import wpcm_pkg::*;

  logic [CELLS:0] link;

  assign link[CELLS] = 1'b0;
  assign old_bit     = link[0];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    wpcm_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .sel       (load_pos == DLY_W'(i)),
      .from_next (link[i+1]),
      .q         (link[i])
    );
  end

endmodule

// ----- design/window_peak_count_max.sv -----
// Top level of the sliding-window peak counter.
// Depends on wpcm_pkg and wpcm_chain.
//
// Input channel: in_valid/in_ready carry one sample and its last flag per item.
// Output channel: out_valid/out_ready carry one result per sequence, produced
// by the item whose last flag is set: best inner peak count plus one, 1-based
// left position of the earliest best window, and a length error flag.
// Config: cfg_wr_en/cfg_wr_data set the window length (clamped to 3..1024),
// latched at the first sample of each sequence.
// Throughput is one item per cycle while in_ready is high: each sample does
// one add and one subtract on the running count, and the peak flag leaving the
// window comes out of a delay line of 1022 cells that shifts once per accepted
// item inside the length bound.
// The result is registered in the output slot, or behind a waiting result.
// Two result slots sit at the output, so the input keeps taking items while a
// result waits; in_ready drops only when both slots hold results.
// Reset clears the sequence state, the result slots and sets the window length
// to 3. The delay line is not cleared; it is only read where written earlier
// in the same sequence.
module window_peak_count_max (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [wpcm_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wpcm_pkg::OUT_W-1:0]         peak_count_plus_one,
  output logic [wpcm_pkg::IDX_W-1:0]         left_position,
  output logic                               length_error,
  input  logic                               cfg_wr_en,
  input  logic [wpcm_pkg::WIN_W-1:0]         cfg_wr_data
);
  import wpcm_pkg::*;

  logic [WIN_W-1:0]       window_len;
  logic [WIN_W-1:0]       held_window;
  logic [SAMPLE_BITS-1:0] prev_sample, older_sample;
  logic [IDX_W-1:0]       sample_index;
  logic [CNT_W-1:0]       window_count, best_count;
  logic [LEFT_W-1:0]      best_left;
  logic                   overlong;

  logic                   accept, active, first, pk, old_bit, take_old, in_range;
  logic [WIN_W-1:0]       held_eff;
  logic [IDX_W-1:0]       j1;
  logic [CNT_W-1:0]       wc_add, window_count_next, best_count_next;
  logic [LEFT_W-1:0]      best_left_next;
  logic [IDX_W-1:0]       sample_index_next;
  logic                   overlong_next;
  cell_ctrl_t             ctrl;
  logic [DLY_W-1:0]       load_pos;

  result_t                res, out_slot, spare_slot;
  logic                   spare_valid, pop, res_valid;

  assign in_ready = !spare_valid;
  assign accept   = in_valid && in_ready;
  assign active   = sample_index < IDX_W'(MAX_LEN);
  assign first    = (sample_index == '0);
  assign held_eff = first ? clamp_window(window_len) : held_window;
  assign pk       = (sample_index >= IDX_W'(2)) && (prev_sample > older_sample)
                    && (prev_sample > sample);
  assign take_old = sample_index >= IDX_W'(held_eff);
  assign j1       = sample_index + IDX_W'(1);
  assign in_range = j1 >= IDX_W'(held_eff);

  always_comb begin
    wc_add = window_count + CNT_W'(pk);
    window_count_next = wc_add;
    if (take_old && old_bit && wc_add != '0) window_count_next = wc_add - CNT_W'(1);
    best_count_next = best_count;
    best_left_next  = best_left;
    if (in_range && (j1 == IDX_W'(held_eff) || window_count_next > best_count)) begin
      best_count_next = window_count_next;
      best_left_next  = LEFT_W'(j1 - IDX_W'(held_eff));
    end
    sample_index_next = active ? j1 : sample_index;
    overlong_next     = overlong || !active;
    res.err   = overlong_next || (sample_index_next < IDX_W'(held_eff));
    res.count = res.err ? '0 : OUT_W'(best_count_next) + OUT_W'(1);
    res.left  = res.err ? '0 : IDX_W'(best_left_next) + IDX_W'(1);
  end

  assign ctrl.shift   = accept && active;
  assign ctrl.load_en = !first;
  assign ctrl.bit_in  = pk;
  assign load_pos     = DLY_W'(held_window - WIN_W'(3));

  wpcm_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .load_pos (load_pos),
    .old_bit  (old_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WIN_W'(3);
    end else if (cfg_wr_en) begin
      window_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_window  <= WIN_W'(3);
      prev_sample  <= '0;
      older_sample <= '0;
      sample_index <= '0;
      window_count <= '0;
      best_count   <= '0;
      best_left    <= '0;
      overlong     <= 1'b0;
    end else if (accept) begin
      if (last) begin
        prev_sample  <= '0;
        older_sample <= '0;
        sample_index <= '0;
        window_count <= '0;
        best_count   <= '0;
        best_left    <= '0;
        overlong     <= 1'b0;
      end else if (active) begin
        held_window  <= held_eff;
        prev_sample  <= sample;
        older_sample <= prev_sample;
        sample_index <= sample_index_next;
        window_count <= window_count_next;
        best_count   <= best_count_next;
        best_left    <= best_left_next;
      end else begin
        overlong <= 1'b1;
      end
      if (last && active) held_window <= held_eff;
    end
  end

  // two result slots
  assign pop       = out_valid && out_ready;
  assign res_valid = accept && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= res_valid;
      end else begin
        out_valid   <= res_valid;
      end
    end else if (res_valid) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (spare_valid) begin
        out_slot <= spare_slot;
        if (res_valid) spare_slot <= res;
      end else if (res_valid) begin
        out_slot <= res;
      end
    end else if (res_valid) begin
      spare_slot <= res;
    end
  end

  assign peak_count_plus_one = out_slot.count;
  assign left_position       = out_slot.left;
  assign length_error        = out_slot.err;

endmodule

// ----- design/wpcm_check.sv -----
// Port-level checks for window_peak_count_max, bound to the top level.
// Depends on wpcm_pkg.
module wpcm_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [wpcm_pkg::OUT_W-1:0]         peak_count_plus_one,
  input logic [wpcm_pkg::IDX_W-1:0]         left_position,
  input logic                               length_error
);
  import wpcm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(peak_count_plus_one)
      && $stable(left_position) && $stable(length_error))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_error |-> peak_count_plus_one == '0 && left_position == '0)
    else $error("error result carries nonzero fields");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !length_error |-> peak_count_plus_one != '0 && left_position != '0
      && peak_count_plus_one <= OUT_W'(MAX_WINDOW - 1))
    else $error("good result out of range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("state not cleared by reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind window_peak_count_max wpcm_check u_wpcm_check (.*);
